// ===== design/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types, codes and constants of the purifier link controller.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'hD2;
  localparam logic [7:0] IDLE_MID     = 8'h80;
  localparam logic [7:0] NOT_RECEIVED = 8'hFF;
  localparam logic [15:0] PERIOD_RESET = 16'd100;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned JQ_DEPTH        = 4;
  localparam int unsigned JQ_AW           = $clog2(JQ_DEPTH);

  // index of the last frame in a transmit burst and of the last byte in a frame
  localparam logic [2:0] LAST_FRAME = 3'd4;
  localparam logic [1:0] LAST_POS   = 2'd2;

  localparam logic [1:0] CMD_CTRL_RX = 2'd0;
  localparam logic [1:0] CMD_BTN_RX  = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_PRESS   = 2'd3;

  localparam logic [2:0] KIND_CTRL_CHANGED = 3'd0;
  localparam logic [2:0] KIND_BTN_CHANGED  = 3'd1;
  localparam logic [2:0] KIND_CTRL_CSUM    = 3'd2;
  localparam logic [2:0] KIND_BTN_CSUM     = 3'd3;
  localparam logic [2:0] KIND_TX           = 3'd4;
  localparam logic [2:0] KIND_OVERFLOW     = 3'd5;

  localparam logic [1:0] REG_SEND_PERIOD = 2'd0;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [23:0] controller_state;
    logic [7:0]  button_state;
    logic        last;
  } out_t;

  // one unit of work for the back end: a single result or a whole burst
  typedef struct packed {
    logic [2:0]  kind;
    logic        burst;
    logic        btn;
    logic [7:0]  code;
    logic [23:0] ctrl_state;
    logic [7:0]  btn_state;
  } job_t;

endpackage

// ===== design/plc_front.sv =====
// ----------------------------------------------------------------------------
// plc_front
// Receive parsers, tick counter and button press queue; turns each
// transaction into at most one job for the back end.
// ----------------------------------------------------------------------------
module plc_front #(
  parameter int unsigned QUEUE_DEPTH = plc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  plc_pkg::in_t   in_data,
  input  logic [15:0]    send_period,
  output logic           job_valid,
  output plc_pkg::job_t  job
);
  import plc_pkg::*;

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = QW + 1;

  logic            ctrl_synced_r, ctrl_synced_nxt;
  logic [1:0]      ctrl_count_r, ctrl_count_nxt;
  logic [7:0]      ctrl_payload_r [3];
  logic [23:0]     ctrl_current_r, ctrl_current_nxt;
  logic            btn_synced_r, btn_synced_nxt;
  logic [7:0]      btn_pending_r, btn_pending_nxt;
  logic [7:0]      btn_current_r, btn_current_nxt;
  logic            just_sent_r, just_sent_nxt;
  logic [15:0]     elapsed_r, elapsed_nxt;
  logic [CW-1:0]   qcount_r, qcount_nxt;
  logic [QW-1:0]   qhead_r, qhead_nxt;

  logic [7:0]      press_mem [QUEUE_DEPTH];
  logic [7:0]      pop_data_r;

  logic            job_valid_r, job_valid_nxt;
  job_t            job_r, job_nxt;

  logic            payload_we;
  logic            press_we;
  logic            pop;
  logic [CW-1:0]   wsum;
  logic [CW-1:0]   widx;
  logic [7:0]      ctrl_sum;
  logic [23:0]     ctrl_st;
  logic [15:0]     elapsed_inc;

  assign ctrl_sum = SYNC_BYTE + ctrl_payload_r[0] + ctrl_payload_r[1] + ctrl_payload_r[2];
  assign ctrl_st  = {ctrl_payload_r[0], ctrl_payload_r[1], ctrl_payload_r[2]};
  assign elapsed_inc = (elapsed_r != 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;

  // tail slot of the circular press queue
  assign wsum = {1'b0, qhead_r} + qcount_r;
  assign widx = (wsum >= CW'(QUEUE_DEPTH)) ? wsum - CW'(QUEUE_DEPTH) : wsum;

  always_comb begin
    ctrl_synced_nxt  = ctrl_synced_r;
    ctrl_count_nxt   = ctrl_count_r;
    ctrl_current_nxt = ctrl_current_r;
    btn_synced_nxt   = btn_synced_r;
    btn_pending_nxt  = btn_pending_r;
    btn_current_nxt  = btn_current_r;
    just_sent_nxt    = just_sent_r;
    elapsed_nxt      = elapsed_r;
    qcount_nxt       = qcount_r;
    qhead_nxt        = qhead_r;
    payload_we       = 1'b0;
    press_we         = 1'b0;
    pop              = 1'b0;
    job_valid_nxt    = 1'b0;
    job_nxt.kind     = KIND_TX;
    job_nxt.burst    = 1'b0;
    job_nxt.btn      = 1'b0;
    job_nxt.code     = 8'h00;

    if (accept) begin
      case (in_data.command)
        CMD_CTRL_RX: begin
          if (!ctrl_synced_r) begin
            ctrl_synced_nxt = (in_data.data_byte == SYNC_BYTE);
          end else if (ctrl_count_r != 2'd3) begin
            payload_we     = 1'b1;
            ctrl_count_nxt = ctrl_count_r + 2'd1;
          end else begin
            ctrl_count_nxt  = 2'd0;
            ctrl_synced_nxt = 1'b0;
            if (ctrl_sum != in_data.data_byte) begin
              job_valid_nxt = 1'b1;
              job_nxt.kind  = KIND_CTRL_CSUM;
            end else if (ctrl_st != ctrl_current_r) begin
              ctrl_current_nxt = ctrl_st;
              job_valid_nxt    = 1'b1;
              job_nxt.kind     = KIND_CTRL_CHANGED;
            end
          end
        end
        CMD_BTN_RX: begin
          if (!btn_synced_r) begin
            btn_synced_nxt = (in_data.data_byte == SYNC_BYTE);
          end else if (btn_pending_r == NOT_RECEIVED) begin
            btn_pending_nxt = in_data.data_byte;
          end else begin
            btn_pending_nxt = NOT_RECEIVED;
            btn_synced_nxt  = 1'b0;
            if (SYNC_BYTE + btn_pending_r != in_data.data_byte) begin
              job_valid_nxt = 1'b1;
              job_nxt.kind  = KIND_BTN_CSUM;
            end else if (btn_pending_r != btn_current_r) begin
              btn_current_nxt = btn_pending_r;
              job_valid_nxt   = 1'b1;
              job_nxt.kind    = KIND_BTN_CHANGED;
            end
          end
        end
        CMD_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= send_period) begin
            elapsed_nxt   = 16'd0;
            job_valid_nxt = 1'b1;
            job_nxt.kind  = KIND_TX;
            job_nxt.burst = 1'b1;
            if (qcount_r == '0 || just_sent_r) begin
              just_sent_nxt = 1'b0;
            end else begin
              just_sent_nxt = 1'b1;
              job_nxt.btn   = 1'b1;
              pop           = 1'b1;
              qcount_nxt    = qcount_r - 1'b1;
              qhead_nxt     = (qhead_r == QW'(QUEUE_DEPTH - 1)) ? '0 : qhead_r + 1'b1;
            end
          end
        end
        default: begin
          if (qcount_r < CW'(QUEUE_DEPTH)) begin
            press_we   = 1'b1;
            qcount_nxt = qcount_r + 1'b1;
          end else begin
            job_valid_nxt = 1'b1;
            job_nxt.kind  = KIND_OVERFLOW;
          end
        end
      endcase
    end

    job_nxt.ctrl_state = ctrl_current_nxt;
    job_nxt.btn_state  = btn_current_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_synced_r  <= 1'b0;
      ctrl_count_r   <= 2'd0;
      ctrl_current_r <= 24'd0;
      btn_synced_r   <= 1'b0;
      btn_pending_r  <= NOT_RECEIVED;
      btn_current_r  <= 8'd0;
      just_sent_r    <= 1'b0;
      elapsed_r      <= 16'd0;
      qcount_r       <= '0;
      qhead_r        <= '0;
      job_valid_r    <= 1'b0;
    end else begin
      ctrl_synced_r  <= ctrl_synced_nxt;
      ctrl_count_r   <= ctrl_count_nxt;
      ctrl_current_r <= ctrl_current_nxt;
      btn_synced_r   <= btn_synced_nxt;
      btn_pending_r  <= btn_pending_nxt;
      btn_current_r  <= btn_current_nxt;
      just_sent_r    <= just_sent_nxt;
      elapsed_r      <= elapsed_nxt;
      qcount_r       <= qcount_nxt;
      qhead_r        <= qhead_nxt;
      job_valid_r    <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (payload_we) begin
      ctrl_payload_r[ctrl_count_r] <= in_data.data_byte;
    end
  end

  // press queue storage, registered read of the head entry
  always_ff @(posedge clk) begin
    if (press_we) begin
      press_mem[widx[QW-1:0]] <= in_data.data_byte;
    end
    if (pop) begin
      pop_data_r <= press_mem[qhead_r];
    end
  end

  always_comb begin
    job      = job_r;
    job.code = job_r.btn ? pop_data_r : 8'h00;
  end

  assign job_valid = job_valid_r;

endmodule

// ===== design/plc_jobq.sv =====
// ----------------------------------------------------------------------------
// plc_jobq
// Short job FIFO between front and back end.
// ----------------------------------------------------------------------------
module plc_jobq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  plc_pkg::job_t                push_job,
  input  logic                         pop,
  output logic                         head_valid,
  output plc_pkg::job_t                head_job,
  output logic [plc_pkg::JQ_AW:0]      count
);
  import plc_pkg::*;

  job_t              slot_r [JQ_DEPTH];
  logic [JQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [JQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [JQ_AW:0]    count_r, count_nxt;

  always_comb begin
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    count_nxt  = count_r + {{JQ_AW{1'b0}}, push} - {{JQ_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign count      = count_r;

endmodule

// ===== design/plc_back.sv =====
// ----------------------------------------------------------------------------
// plc_back
// Result sequencer: expands a job into one result or a 15-byte burst and
// holds each result in the output register until taken.
// ----------------------------------------------------------------------------
module plc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  plc_pkg::job_t  job,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output plc_pkg::out_t  out_data
);
  import plc_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;
  logic [2:0]  frame_r, frame_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        load;
  logic        burst_end;
  logic [7:0]  mid;

  assign load      = !out_valid_r || !out_stall;
  assign burst_end = (frame_r == LAST_FRAME) && (pos_r == LAST_POS);
  // first frame carries 0x80 on top of the code, the repeats the bare code
  assign mid       = ((frame_r == 3'd0) ? IDLE_MID : 8'h00) + job.code;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    frame_nxt     = frame_r;
    pos_nxt       = pos_r;
    job_pop       = 1'b0;

    if (load) begin
      out_valid_nxt            = job_valid;
      out_nxt.kind             = job.kind;
      out_nxt.controller_state = job.ctrl_state;
      out_nxt.button_state     = job.btn_state;
      out_nxt.tx_byte          = 8'h00;
      out_nxt.last             = 1'b1;
      if (job_valid) begin
        if (job.burst) begin
          case (pos_r)
            2'd0:    out_nxt.tx_byte = SYNC_BYTE;
            2'd1:    out_nxt.tx_byte = mid;
            default: out_nxt.tx_byte = SYNC_BYTE + mid;
          endcase
          out_nxt.last = burst_end;
          if (burst_end) begin
            frame_nxt = 3'd0;
            pos_nxt   = 2'd0;
            job_pop   = 1'b1;
          end else if (pos_r == LAST_POS) begin
            frame_nxt = frame_r + 3'd1;
            pos_nxt   = 2'd0;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end else begin
          job_pop = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      frame_r     <= 3'd0;
      pos_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      frame_r     <= frame_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/purifier_link_controller.sv =====
// ----------------------------------------------------------------------------
// purifier_link_controller
// Controller and button receive links, periodic transmit bursts and a
// button press queue behind one transaction stream.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock while in_stall is low; each
// gives at most one job to a four-entry job queue. The back end turns a job
// into one result or a 15-byte transmit burst on the result port. A job goes
// through the front end's job register and the job queue before the back end's
// output register shows its first result at out_valid. in_stall rises only
// when the job queue and the stage in front of it hold four jobs, so the
// result port's drain rate of one result per cycle while out_stall is low
// bounds sustained throughput while bursts are outstanding. send_period sits at byte address 0.
module purifier_link_controller #(
  parameter int unsigned QUEUE_DEPTH = plc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  plc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output plc_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import plc_pkg::*;

  logic [15:0]     send_period_r;
  logic            cfg_wr;
  logic            accept;
  logic            fr_job_valid;
  job_t            fr_job;
  logic            jq_valid;
  job_t            jq_job;
  logic            jq_pop;
  logic [JQ_AW:0]  jq_count;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:1] == REG_SEND_PERIOD);
  assign prdata = (paddr[2:1] == REG_SEND_PERIOD) ? {16'd0, send_period_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_period_r <= PERIOD_RESET;
    end else if (cfg_wr) begin
      send_period_r <= pwdata[15:0];
    end
  end

  // room for the job of this transaction and the one already in flight
  assign in_stall = ({1'b0, jq_count} + {{(JQ_AW+1){1'b0}}, fr_job_valid})
                    >= (JQ_AW+2)'(JQ_DEPTH);
  assign accept   = in_valid && !in_stall;

  plc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .send_period (send_period_r),
    .job_valid   (fr_job_valid),
    .job         (fr_job)
  );

  plc_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fr_job_valid),
    .push_job   (fr_job),
    .pop        (jq_pop),
    .head_valid (jq_valid),
    .head_job   (jq_job),
    .count      (jq_count)
  );

  plc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (jq_valid),
    .job       (jq_job),
    .job_pop   (jq_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_jq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fr_job_valid |-> (jq_count < (JQ_AW+1)'(JQ_DEPTH)))
    else $error("job queue pushed while full");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != KIND_TX) |-> (out_data.last && out_data.tx_byte == 8'h00))
    else $error("non-transmit result not marked last or carries a byte");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    jq_pop |-> jq_valid)
    else $error("job queue popped while empty");

  a_burst_starts_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last && out_data.kind == KIND_TX)
      |=> (!out_valid || out_data.kind != KIND_TX || out_data.tx_byte == SYNC_BYTE))
    else $error("transmit burst does not open with the sync byte");
`endif

endmodule
